FILE: hdl/psel_pkg.sv
package psel_pkg;

  // One stored candidate, as held in the candidate memory.
  typedef struct packed {
    logic [15:0] peer;
    logic [32:0] grp;   // known flag above the key, all zero when unknown
    logic [16:0] ping;  // unknown ping sits above every measured one
    logic [47:0] hdr;
    logic [47:0] conn;
  } psel_entry_t;

  typedef struct packed {
    logic [3:0] ng;
    logic [5:0] ping;
    logic [5:0] hdr;
  } psel_cfg_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] peer;
  } psel_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_NEXT, ST_LDI, ST_WI, ST_SCAN, ST_DEC, ST_APPLY, ST_OUT
  } psel_state_e;

  typedef enum logic [3:0] {
    PASS_INIT, PASS_FIRSTA, PASS_NG, PASS_PING, PASS_HDR, PASS_AGE,
    PASS_FIRSTB, PASS_GRP, PASS_PICK
  } psel_pass_e;

  typedef enum logic [1:0] {
    CFG_NG   = 2'd0,
    CFG_PING = 2'd1,
    CFG_HDR  = 2'd2
  } psel_cfg_idx_e;

  localparam logic [16:0] UNKNOWN_PING = 17'h10000;
  localparam logic [3:0]  NG_RESET     = 4'd4;
  localparam logic [5:0]  PING_RESET   = 6'd8;
  localparam logic [5:0]  HDR_RESET    = 6'd4;

endpackage

FILE: hdl/psel_store.sv
module psel_store #(
  parameter int DEPTH = 128,
  parameter int IW    = 7
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IW-1:0]         waddr_i,
  input  psel_pkg::psel_entry_t wdata_i,
  input  logic [IW-1:0]         raddr_i,
  output psel_pkg::psel_entry_t rdata_o
);
  import psel_pkg::*;

  psel_entry_t mem [DEPTH];
  psel_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/psel_seq.sv
module psel_seq #(
  parameter int MAX_CANDIDATES = 128,
  parameter int CW             = 8,
  parameter int IW             = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psel_pkg::psel_cfg_t   cfg_i,
  input  logic                  load_i,
  input  logic                  last_i,
  input  logic                  alive_i,
  input  psel_pkg::psel_entry_t entry_i,
  input  logic                  out_free_i,
  output logic                  busy_o,
  output psel_pkg::psel_res_t   res_o,
  output logic                  we_o,
  output logic [IW-1:0]         waddr_o,
  output psel_pkg::psel_entry_t wdata_o,
  output logic [IW-1:0]         raddr_o,
  input  psel_pkg::psel_entry_t rdata_i
);
  import psel_pkg::*;

  localparam int XW = CW + 7;

  psel_state_e state_q, state_d;
  psel_pass_e  pass_q, np;
  logic        guard;

  logic [CW-1:0] cnt_q, alive_cnt_q, n_q, dcnt_q, i_q, j_q, mcnt_q;
  logic [IW-1:0] rj_q;
  logic          rv_q;
  logic [MAX_CANDIDATES-1:0] alive_q, pool_q, drop_q, first_q;
  psel_entry_t   ent_q;
  logic [47:0]   young_q, best_young_q;
  logic [CW-1:0] best_size_q;
  logic [32:0]   best_grp_q;
  logic          have_q, found_q;
  logic [15:0]   victim_q;

  logic          elig, match, tail_drop, better;
  logic [XW-1:0] kx;
  logic [IW-1:0] ii;

  assign ii = i_q[IW-1:0];

  // Which pass follows, and whether its size guard lets it run.
  always_comb begin
    np    = PASS_PICK;
    guard = 1'b1;
    case (pass_q)
      PASS_INIT: begin
        np    = PASS_FIRSTA;
        guard = XW'(n_q) > XW'(cfg_i.ng);
      end
      PASS_FIRSTA: begin
        np    = PASS_NG;
        guard = XW'(n_q) > XW'(cfg_i.ng);
      end
      PASS_NG: begin
        np    = PASS_PING;
        guard = XW'(n_q) > XW'(cfg_i.ping);
      end
      PASS_PING: begin
        np    = PASS_HDR;
        guard = XW'(n_q) > XW'(cfg_i.hdr);
      end
      PASS_HDR: begin
        np    = PASS_AGE;
        guard = n_q > CW'(1);
      end
      PASS_AGE:    np = PASS_FIRSTB;
      PASS_FIRSTB: np = PASS_GRP;
      PASS_GRP:    np = PASS_PICK;
      default:     np = PASS_PICK;
    endcase
  end

  // Eligibility of candidate i, from the word just read back.
  always_comb begin
    case (pass_q)
      PASS_NG:     elig = pool_q[ii] && (rdata_i.grp != '0) && first_q[ii];
      PASS_GRP:    elig = pool_q[ii] && first_q[ii];
      PASS_PICK:   elig = pool_q[ii] && (rdata_i.grp == best_grp_q)
                          && (rdata_i.conn == best_young_q);
      default:     elig = pool_q[ii];
    endcase
  end

  // Does candidate j (read back) count against candidate i?
  always_comb begin
    case (pass_q)
      PASS_FIRSTA, PASS_FIRSTB:
        match = pool_q[rj_q] && (CW'(rj_q) < i_q) && (rdata_i.grp == ent_q.grp);
      PASS_NG:
        match = pool_q[rj_q] && first_q[rj_q] && (rdata_i.grp > ent_q.grp);
      PASS_PING:
        match = pool_q[rj_q] && ((rdata_i.ping > ent_q.ping) ||
                ((rdata_i.ping == ent_q.ping) && (CW'(rj_q) < i_q)));
      PASS_HDR:
        match = pool_q[rj_q] && ((rdata_i.hdr < ent_q.hdr) ||
                ((rdata_i.hdr == ent_q.hdr) && (CW'(rj_q) < i_q)));
      PASS_AGE:
        match = pool_q[rj_q] && ((rdata_i.conn > ent_q.conn) ||
                ((rdata_i.conn == ent_q.conn) && (CW'(rj_q) < i_q)));
      PASS_GRP:
        match = pool_q[rj_q] && (rdata_i.grp == ent_q.grp);
      default:
        match = 1'b0;
    endcase
  end

  always_comb begin
    case (pass_q)
      PASS_PING: kx = XW'(cfg_i.ping);
      PASS_HDR:  kx = XW'(cfg_i.hdr);
      default:   kx = XW'(n_q >> 1);
    endcase
  end

  assign tail_drop = (XW'(mcnt_q) + kx) >= XW'(n_q);
  assign better = !have_q || (mcnt_q > best_size_q) ||
                  ((mcnt_q == best_size_q) && (young_q > best_young_q)) ||
                  ((mcnt_q == best_size_q) && (young_q == best_young_q) &&
                   (ent_q.grp < best_grp_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (load_i && last_i) state_d = ST_START;
      ST_START: state_d = ST_NEXT;
      ST_NEXT: begin
        if (n_q == '0) begin
          state_d = ST_OUT;
        end else if (guard) begin
          state_d = ST_LDI;
        end
      end
      ST_LDI: begin
        if (i_q >= cnt_q) begin
          state_d = (pass_q == PASS_PICK) ? ST_OUT : ST_APPLY;
        end else begin
          state_d = ST_WI;
        end
      end
      ST_WI: begin
        if (elig) begin
          state_d = (pass_q == PASS_PICK) ? ST_OUT : ST_SCAN;
        end else begin
          state_d = ST_LDI;
        end
      end
      ST_SCAN:  if (j_q >= cnt_q && !rv_q) state_d = ST_DEC;
      ST_DEC:   state_d = ST_LDI;
      ST_APPLY: state_d = ST_NEXT;
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o    = state_q != ST_IDLE;
    we_o      = (state_q == ST_IDLE) && load_i && (cnt_q < CW'(MAX_CANDIDATES));
    waddr_o   = cnt_q[IW-1:0];
    wdata_o   = entry_i;
    raddr_o   = (state_q == ST_SCAN) ? j_q[IW-1:0] : ii;
    res_o     = '{valid: state_q == ST_OUT, found: found_q, peer: victim_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_INIT;
      cnt_q       <= '0;
      alive_cnt_q <= '0;
      dcnt_q      <= '0;
      drop_q      <= '0;
      rv_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (we_o) begin
            cnt_q       <= cnt_q + CW'(1);
            alive_cnt_q <= alive_cnt_q + CW'(alive_i);
          end
        end
        ST_START: pass_q <= PASS_INIT;
        ST_NEXT:  if (n_q != '0) pass_q <= np;
        ST_LDI:   rv_q <= 1'b0;
        ST_SCAN:  rv_q <= j_q < cnt_q;
        ST_DEC: begin
          if (((pass_q == PASS_NG) && (XW'(mcnt_q) < XW'(cfg_i.ng))) ||
              (((pass_q == PASS_PING) || (pass_q == PASS_HDR) ||
                (pass_q == PASS_AGE)) && tail_drop)) begin
            drop_q[ii] <= 1'b1;
            dcnt_q     <= dcnt_q + CW'(1);
          end
        end
        ST_APPLY: begin
          drop_q <= '0;
          dcnt_q <= '0;
        end
        ST_OUT: begin
          if (out_free_i) begin
            cnt_q       <= '0;
            alive_cnt_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (we_o) alive_q[cnt_q[IW-1:0]] <= alive_i;
      ST_START: begin
        pool_q   <= alive_q;
        n_q      <= alive_cnt_q;
        have_q   <= 1'b0;
        found_q  <= 1'b0;
        victim_q <= '0;
      end
      ST_NEXT: i_q <= '0;
      ST_LDI: begin
        j_q     <= '0;
        mcnt_q  <= '0;
        young_q <= '0;
      end
      ST_WI: begin
        ent_q <= rdata_i;
        if (!elig) begin
          if (pass_q == PASS_FIRSTA || pass_q == PASS_FIRSTB) first_q[ii] <= 1'b0;
          i_q <= i_q + CW'(1);
        end else if (pass_q == PASS_PICK) begin
          found_q  <= 1'b1;
          victim_q <= rdata_i.peer;
        end
      end
      ST_SCAN: begin
        if (j_q < cnt_q) j_q <= j_q + CW'(1);
        rj_q <= j_q[IW-1:0];
        if (rv_q && match) begin
          mcnt_q <= mcnt_q + CW'(1);
          if (rdata_i.conn > young_q) young_q <= rdata_i.conn;
        end
      end
      ST_DEC: begin
        if (pass_q == PASS_FIRSTA || pass_q == PASS_FIRSTB) first_q[ii] <= mcnt_q == '0;
        if ((pass_q == PASS_GRP) && better) begin
          have_q       <= 1'b1;
          best_size_q  <= mcnt_q;
          best_young_q <= young_q;
          best_grp_q   <= ent_q.grp;
        end
        i_q <= i_q + CW'(1);
      end
      ST_APPLY: begin
        pool_q <= pool_q & ~drop_q;
        n_q    <= n_q - dcnt_q;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/peer_eviction_selector_core.sv
// Loading a candidate is a single write into the candidate memory.
// After the beat marked last, selection runs up to seven comparing passes over the
// memory, each reading every eligible candidate against every stored one through
// the single read port; a pass whose size guard fails is skipped, and a final pass
// picks the victim.
// Input is stalled during selection until the result beat is registered.
// Reset clears the control state, the candidate count and the output valid, and loads the configuration defaults.
module peer_eviction_selector_core #(
  parameter int MAX_CANDIDATES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] peer_id_i,
  input  logic [31:0] group_key_i,
  input  logic        group_known_i,
  input  logic        outbound_i,
  input  logic        protected_flag_i,
  input  logic        ping_known_i,
  input  logic [15:0] ping_ms_i,
  input  logic [47:0] headers_time_i,
  input  logic [47:0] connect_time_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [15:0] evict_peer_id_o
);
  import psel_pkg::*;

  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int IW = $clog2(MAX_CANDIDATES);

  psel_cfg_t   cfg_q;
  psel_entry_t entry, wdata, rdata;
  psel_res_t   res;
  logic        busy, load, out_free, we;
  logic [IW-1:0] waddr, raddr;
  logic        out_valid_q, found_q;
  logic [15:0] peer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ng: NG_RESET, ping: PING_RESET, hdr: HDR_RESET};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NG:   cfg_q.ng   <= cfg_wdata_i[3:0];
        CFG_PING: cfg_q.ping <= cfg_wdata_i;
        CFG_HDR:  cfg_q.hdr  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign load       = in_valid_i && !busy;

  always_comb begin
    entry.peer = peer_id_i;
    entry.grp  = group_known_i ? {1'b1, group_key_i} : 33'd0;
    entry.ping = ping_known_i ? {1'b0, ping_ms_i} : UNKNOWN_PING;
    entry.hdr  = headers_time_i;
    entry.conn = connect_time_i;
  end

  psel_seq #(.MAX_CANDIDATES(MAX_CANDIDATES), .CW(CW), .IW(IW)) u_seq (
    .clk_i, .rst_ni,
    .cfg_i      (cfg_q),
    .load_i     (load),
    .last_i     (last_i),
    .alive_i    (!outbound_i && !protected_flag_i),
    .entry_i    (entry),
    .out_free_i (out_free),
    .busy_o     (busy),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  psel_store #(.DEPTH(MAX_CANDIDATES), .IW(IW)) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      found_q <= res.found;
      peer_q  <= res.peer;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign evict_peer_id_o = peer_q;

endmodule

FILE: hdl/psel_chk.sv
module psel_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        found_o,
  input logic [15:0] evict_peer_id_o
);

  // A held result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // An empty result carries a zero identifier.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> evict_peer_id_o == 16'd0)
    else $error("identifier set without a chosen peer");

  // The final beat of a set starts selection, which stalls the input.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after final beat");

  // A result only appears out of a selection in progress.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without selection");

endmodule

bind peer_eviction_selector_core psel_chk u_chk (.*);
